// ===== hw/rtl/ssa_pkg.sv =====
// ----------------------------------------------------------------------------
// ssa_pkg
// Shared types, codes and helpers for the swap slot allocator.
// ----------------------------------------------------------------------------
package ssa_pkg;

  localparam int WORD_W     = 32;
  localparam int BIT_W      = 5;
  localparam int ACTION_W   = 2;
  localparam int INDEX_W    = 10;
  localparam int SLOT_W     = 10;
  localparam int SECTOR_W   = 13;
  localparam int TRANSFER_W = 2;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 11;

  localparam logic [ACTION_W-1:0] ACT_SWAP_OUT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_SWAP_IN  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FREE     = 2'd2;

  localparam logic [TRANSFER_W-1:0] XFER_NONE  = 2'd0;
  localparam logic [TRANSFER_W-1:0] XFER_READ  = 2'd1;
  localparam logic [TRANSFER_W-1:0] XFER_WRITE = 2'd2;

  localparam logic [STATUS_W-1:0] STS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STS_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STS_NOT_USED = 2'd2;
  localparam logic [STATUS_W-1:0] STS_RANGE    = 2'd3;

  localparam logic [COUNT_W-1:0] SLOT_COUNT_RST = 11'd1024;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_EMIT
  } ssa_state_t;

  // lowest set bit of a bitmap word
  function automatic logic [BIT_W-1:0] ssa_first_set(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) begin
        pos = BIT_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

// ===== hw/rtl/swap_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// swap_slot_allocator
// Free bitmap over swap slots with per-sector address generation.
// ----------------------------------------------------------------------------
// Request words arrive on in_* (action, slot_index); result words leave on
// out_* (slot, sector, transfer, status, last), one to eight per request,
// the final one flagged by out_last. cfg_* writes the slot count; the
// user must write it only while the block is idle, and the block itself
// does not enforce this. The bitmap sits in a RAM of 32-bit words. After
// reset a clearing pass writes every word to all free, with in_ready low.
// Swap out scans one bitmap word per cycle through the RAM read port,
// then gives one result per sector. Swap in reads the bitmap word and
// checks the bit, then gives one result per sector. Free, out of range
// and not in use cases give one result, as does a full table found by
// the scan. Sector addresses come from one constant multiply and add per
// result. Results pass through an output register; a stalled receiver
// holds the sequencer in its emit step, and the next request is taken
// once the last result is loaded into that register. Action 3 is taken
// and dropped.
// ----------------------------------------------------------------------------
module swap_slot_allocator
  import ssa_pkg::*;
#(
  parameter int MAX_SLOTS        = 1024,
  parameter int SECTORS_PER_SLOT = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [COUNT_W-1:0]    cfg_slot_count,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ACTION_W-1:0]   in_action,
  input  logic [INDEX_W-1:0]    in_slot_index,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SLOT_W-1:0]     out_slot,
  output logic [SECTOR_W-1:0]   out_sector,
  output logic [TRANSFER_W-1:0] out_transfer,
  output logic [STATUS_W-1:0]   out_status,
  output logic                  out_last
);

  localparam int WORDS  = (MAX_SLOTS + WORD_W - 1) / WORD_W;
  localparam int WA_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int RS_W   = (WA_W + BIT_W > INDEX_W) ? WA_W + BIT_W : INDEX_W;
  localparam int CMP_W  = (WA_W + BIT_W + 1 > COUNT_W) ? WA_W + BIT_W + 1 : COUNT_W;
  localparam int SPS_W  = $clog2(SECTORS_PER_SLOT + 1);
  localparam int OFF_W  = (SECTORS_PER_SLOT > 1) ? $clog2(SECTORS_PER_SLOT) : 1;
  localparam int PROD_W = (RS_W + SPS_W > SECTOR_W) ? RS_W + SPS_W : SECTOR_W;

  ssa_state_t state_r, state_nxt;

  logic [COUNT_W-1:0]    slot_count_r;
  logic [WA_W-1:0]       clr_w_r, clr_w_nxt;
  logic [WA_W-1:0]       scan_w_r, scan_w_nxt;
  logic [WA_W-1:0]       chk_w_r, chk_w_nxt;
  logic [RS_W-1:0]       idx_r, idx_nxt;
  logic [ACTION_W-1:0]   act_r, act_nxt;
  logic [RS_W-1:0]       res_slot_r, res_slot_nxt;
  logic [TRANSFER_W-1:0] res_xfer_r, res_xfer_nxt;
  logic [STATUS_W-1:0]   res_status_r, res_status_nxt;
  logic [OFF_W-1:0]      off_r, off_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0]     out_slot_r, out_slot_nxt;
  logic [SECTOR_W-1:0]   out_sector_r, out_sector_nxt;
  logic [TRANSFER_W-1:0] out_xfer_r, out_xfer_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  mem_we;
  logic [WA_W-1:0]       mem_waddr;
  logic [WORD_W-1:0]     mem_wdata;
  logic [WA_W-1:0]       mem_raddr;
  logic [WORD_W-1:0]     mem_rdata;

  logic [CMP_W-1:0]      cnt_ext, max_ext, usable;
  logic [RS_W-1:0]       in_idx_ext;
  logic [CMP_W-1:0]      base_ext, rem;
  logic [WORD_W-1:0]     scan_mask, scan_hits;
  logic [BIT_W-1:0]      hit_pos;
  logic                  scan_end;
  logic [WA_W-1:0]       idx_word;
  logic [WORD_W-1:0]     idx_bit;
  logic [PROD_W-1:0]     sector_full;
  logic                  emit_last;

  ssa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS),
    .ADDR_W(WA_W)
  ) u_bitmap (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign cnt_ext    = CMP_W'(slot_count_r);
  assign max_ext    = CMP_W'(MAX_SLOTS);
  assign usable     = (cnt_ext < max_ext) ? cnt_ext : max_ext;
  assign in_idx_ext = RS_W'(in_slot_index);

  // valid bits of the word under check
  assign base_ext  = CMP_W'({chk_w_r, {BIT_W{1'b0}}});
  assign rem       = usable - base_ext;
  assign scan_end  = (rem <= CMP_W'(WORD_W));
  assign scan_mask = (rem >= CMP_W'(WORD_W)) ? '1 :
                     ((WORD_W'(1) << rem[BIT_W-1:0]) - WORD_W'(1));
  assign scan_hits = mem_rdata & scan_mask;
  assign hit_pos   = ssa_first_set(scan_hits);

  assign idx_word = idx_r[WA_W+BIT_W-1:BIT_W];
  assign idx_bit  = WORD_W'(1) << idx_r[BIT_W-1:0];

  assign sector_full = PROD_W'(res_slot_r) * PROD_W'(SECTORS_PER_SLOT) + PROD_W'(off_r);
  assign emit_last   = (res_xfer_r == XFER_NONE) ||
                       (off_r == OFF_W'(SECTORS_PER_SLOT - 1));

  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt      = state_r;
    clr_w_nxt      = clr_w_r;
    scan_w_nxt     = scan_w_r;
    chk_w_nxt      = chk_w_r;
    idx_nxt        = idx_r;
    act_nxt        = act_r;
    res_slot_nxt   = res_slot_r;
    res_xfer_nxt   = res_xfer_r;
    res_status_nxt = res_status_r;
    off_nxt        = off_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_slot_nxt   = out_slot_r;
    out_sector_nxt = out_sector_r;
    out_xfer_nxt   = out_xfer_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_waddr      = chk_w_r;
    mem_wdata      = mem_rdata;
    mem_raddr      = scan_w_r;
    in_ready       = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_w_r;
        mem_wdata = '1;
        if (clr_w_r == WA_W'(WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_w_nxt = clr_w_r + WA_W'(1);
        end
      end

      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          act_nxt = in_action;
          idx_nxt = in_idx_ext;
          off_nxt = '0;
          priority if (in_action == ACT_SWAP_OUT) begin
            if (usable == '0) begin
              res_slot_nxt   = '0;
              res_xfer_nxt   = XFER_NONE;
              res_status_nxt = STS_FULL;
              state_nxt      = ST_EMIT;
            end else begin
              mem_raddr  = '0;
              scan_w_nxt = WA_W'(1);
              chk_w_nxt  = '0;
              state_nxt  = ST_SCAN;
            end
          end else if (in_action == ACT_SWAP_IN || in_action == ACT_FREE) begin
            if (CMP_W'(in_slot_index) >= usable) begin
              res_slot_nxt   = in_idx_ext;
              res_xfer_nxt   = XFER_NONE;
              res_status_nxt = STS_RANGE;
              state_nxt      = ST_EMIT;
            end else begin
              mem_raddr = in_idx_ext[WA_W+BIT_W-1:BIT_W];
              state_nxt = ST_CHECK;
            end
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_SCAN: begin
        mem_raddr  = scan_w_r;
        scan_w_nxt = scan_w_r + WA_W'(1);
        chk_w_nxt  = scan_w_r;
        if (scan_hits != '0) begin
          mem_we         = 1'b1;
          mem_waddr      = chk_w_r;
          mem_wdata      = mem_rdata & ~(WORD_W'(1) << hit_pos);
          res_slot_nxt   = RS_W'({chk_w_r, hit_pos});
          res_xfer_nxt   = XFER_WRITE;
          res_status_nxt = STS_OK;
          state_nxt      = ST_EMIT;
        end else if (scan_end) begin
          res_slot_nxt   = '0;
          res_xfer_nxt   = XFER_NONE;
          res_status_nxt = STS_FULL;
          state_nxt      = ST_EMIT;
        end
      end

      ST_CHECK: begin
        res_slot_nxt = idx_r;
        state_nxt    = ST_EMIT;
        if ((mem_rdata & idx_bit) != '0) begin
          res_xfer_nxt   = XFER_NONE;
          res_status_nxt = STS_NOT_USED;
        end else begin
          mem_we         = 1'b1;
          mem_waddr      = idx_word;
          mem_wdata      = mem_rdata | idx_bit;
          res_xfer_nxt   = (act_r == ACT_SWAP_IN) ? XFER_READ : XFER_NONE;
          res_status_nxt = STS_OK;
        end
      end

      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_slot_nxt   = res_slot_r[SLOT_W-1:0];
          out_sector_nxt = (res_xfer_r == XFER_NONE) ? '0 : sector_full[SECTOR_W-1:0];
          out_xfer_nxt   = res_xfer_r;
          out_status_nxt = res_status_r;
          out_last_nxt   = emit_last;
          if (emit_last) begin
            state_nxt = ST_IDLE;
          end else begin
            off_nxt = off_r + OFF_W'(1);
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_w_r      <= '0;
      slot_count_r <= SLOT_COUNT_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_w_r     <= clr_w_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        slot_count_r <= cfg_slot_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_w_r     <= scan_w_nxt;
    chk_w_r      <= chk_w_nxt;
    idx_r        <= idx_nxt;
    act_r        <= act_nxt;
    res_slot_r   <= res_slot_nxt;
    res_xfer_r   <= res_xfer_nxt;
    res_status_r <= res_status_nxt;
    off_r        <= off_nxt;
    out_slot_r   <= out_slot_nxt;
    out_sector_r <= out_sector_nxt;
    out_xfer_r   <= out_xfer_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_slot     = out_slot_r;
  assign out_sector   = out_sector_r;
  assign out_transfer = out_xfer_r;
  assign out_status   = out_status_r;
  assign out_last     = out_last_r;

  // clearing pass only ever marks words free
  a_clear_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> (mem_we && mem_wdata == '1))
    else $error("clearing pass wrote a non-free word");

  // bitmap untouched while waiting for a request
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !mem_we)
    else $error("bitmap written while idle");

  // error results are single words
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STS_OK) |-> (out_last && out_transfer == XFER_NONE))
    else $error("error result not final or carries a transfer");

  // no transfer means sector zero
  a_none_sector: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_transfer == XFER_NONE) |-> (out_sector == '0))
    else $error("sector set on a result without transfer");

  // a found slot is written back as used in the same cycle
  a_scan_claim: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && state_nxt == ST_EMIT && res_xfer_nxt == XFER_WRITE)
      |-> (mem_we && mem_waddr == chk_w_r))
    else $error("allocated slot not marked used");

endmodule

// ===== hw/rtl/ssa_ram.sv =====
// ----------------------------------------------------------------------------
// ssa_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module ssa_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for swap_slot_allocator. Requests are driven on in_*
// and slot counts on cfg_*. A predictor keeps its own free bitmap and slot
// count, turns each accepted request into expected result words, and
// checks every accepted word on out_* in order. The run covers a directed
// opening, a fill of the table at a reduced slot count, and random phases
// at several slot counts, with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ssa_pkg::*;

  localparam int SLOTS   = 1024;
  localparam int SECTORS = 8;
  localparam int LIMIT   = 400000;
  localparam int FILL_COUNT = 100;
  localparam int PHASE_REQS = 35;

  localparam logic [ACTION_W-1:0] ACT_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [SLOT_W-1:0]     slot;
    logic [SECTOR_W-1:0]   sector;
    logic [TRANSFER_W-1:0] transfer;
    logic [STATUS_W-1:0]   status;
    logic                  last;
  } out_word_t;

  class swap_predictor;
    bit                 slot_free [SLOTS];
    logic [COUNT_W-1:0] slot_count_q;
    out_word_t          due_words [$];
    int                 mismatches;

    function new();
      foreach (slot_free[s]) slot_free[s] = 1'b1;
      slot_count_q = SLOT_COUNT_RST;
      mismatches   = 0;
    endfunction

    function int usable();
      return (int'(slot_count_q) < SLOTS) ? int'(slot_count_q) : SLOTS;
    endfunction

    function void set_count(logic [COUNT_W-1:0] v);
      slot_count_q = v;
    endfunction

    function void push_word(int s, int sec, logic [TRANSFER_W-1:0] xfer,
                            logic [STATUS_W-1:0] sts, bit lst);
      out_word_t w;
      w.slot     = SLOT_W'(s);
      w.sector   = SECTOR_W'(sec);
      w.transfer = xfer;
      w.status   = sts;
      w.last     = lst;
      due_words.push_back(w);
    endfunction

    function void push_sectors(int s, logic [TRANSFER_W-1:0] xfer);
      for (int i = 0; i < SECTORS; i++) begin
        push_word(s, s * SECTORS + i, xfer, STS_OK, i == SECTORS - 1);
      end
    endfunction

    function void take_request(logic [ACTION_W-1:0] act, logic [INDEX_W-1:0] idx);
      int n;
      int s;
      n = usable();
      case (act)
        ACT_SWAP_OUT: begin
          s = 0;
          while (s < n && !slot_free[s]) s++;
          if (s >= n) begin
            push_word(0, 0, XFER_NONE, STS_FULL, 1'b1);
          end else begin
            slot_free[s] = 1'b0;
            push_sectors(s, XFER_WRITE);
          end
        end
        ACT_SWAP_IN, ACT_FREE: begin
          if (int'(idx) >= n) begin
            push_word(idx, 0, XFER_NONE, STS_RANGE, 1'b1);
          end else if (slot_free[idx]) begin
            push_word(idx, 0, XFER_NONE, STS_NOT_USED, 1'b1);
          end else begin
            slot_free[idx] = 1'b1;
            if (act == ACT_SWAP_IN) begin
              push_sectors(idx, XFER_READ);
            end else begin
              push_word(idx, 0, XFER_NONE, STS_OK, 1'b1);
            end
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (due_words.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected word: slot %0d sector %0d transfer %0d status %0d last %0d",
                   got.slot, got.sector, got.transfer, got.status, got.last);
        end
        mismatches++;
        return;
      end
      want = due_words.pop_front();
      if (got !== want) begin
        if (mismatches < 10) begin
          $display({"mismatch: slot %0d/%0d sector %0d/%0d transfer %0d/%0d",
                    " status %0d/%0d last %0d/%0d (exp/got)"},
                   want.slot, got.slot, want.sector, got.sector, want.transfer,
                   got.transfer, want.status, got.status, want.last, got.last);
        end
        mismatches++;
      end
    endfunction

    function int free_below();
      int c;
      c = 0;
      for (int s = 0; s < usable(); s++) if (slot_free[s]) c++;
      return c;
    endfunction

    function int random_used();
      int picks [$];
      for (int s = 0; s < usable(); s++) if (!slot_free[s]) picks.push_back(s);
      if (picks.size() == 0) return -1;
      return picks[$urandom_range(picks.size() - 1)];
    endfunction

    function int pending();
      return due_words.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [COUNT_W-1:0]    cfg_slot_count = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [ACTION_W-1:0]   in_action = '0;
  logic [INDEX_W-1:0]    in_slot_index = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [SLOT_W-1:0]     out_slot;
  logic [SECTOR_W-1:0]   out_sector;
  logic [TRANSFER_W-1:0] out_transfer;
  logic [STATUS_W-1:0]   out_status;
  logic                  out_last;

  bit          calm = 1'b0;
  int unsigned cycle_count = 0;
  swap_predictor sb = new();

  swap_slot_allocator #(
    .MAX_SLOTS        (SLOTS),
    .SECTORS_PER_SLOT (SECTORS)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_slot_count (cfg_slot_count),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_slot_index  (in_slot_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_slot       (out_slot),
    .out_sector     (out_sector),
    .out_transfer   (out_transfer),
    .out_status     (out_status),
    .out_last       (out_last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 7);
  end

  always @(posedge clk) begin
    out_word_t got;
    if (rst_n && out_valid && out_ready) begin
      got.slot     = out_slot;
      got.sector   = out_sector;
      got.transfer = out_transfer;
      got.status   = out_status;
      got.last     = out_last;
      sb.check_word(got);
    end
  end

  initial begin : watchdog
    while (cycle_count < LIMIT) @(posedge clk);
    $display("testbench: errors");
    $finish;
  end

  // called just after a falling edge; leaves in_valid high on return
  task automatic send_request(logic [ACTION_W-1:0] act, logic [INDEX_W-1:0] idx);
    if (!calm && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_slot_index <= idx;
    do @(posedge clk); while (!(in_valid && in_ready));
    sb.take_request(act, idx);
    @(negedge clk);
  endtask

  task automatic wait_idle(int extra);
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_slot_count(logic [COUNT_W-1:0] v);
    wait_idle(SECTORS * 2);
    cfg_valid      <= 1'b1;
    cfg_slot_count <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    sb.set_count(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_request(output logic [ACTION_W-1:0] act);
    int r;
    int used;
    logic [INDEX_W-1:0] idx;
    r   = $urandom_range(99);
    idx = INDEX_W'($urandom_range(SLOTS - 1));
    act = ACT_SWAP_OUT;
    if (r >= 45 && r < 85) begin
      used = sb.random_used();
      if (used >= 0) begin
        act = $urandom_range(1) ? ACT_SWAP_IN : ACT_FREE;
        idx = INDEX_W'(used);
      end
    end else if (r >= 85 && r < 95) begin
      act = $urandom_range(1) ? ACT_SWAP_IN : ACT_FREE;
    end else if (r >= 95) begin
      act = ACT_UNKNOWN;
    end
    send_request(act, idx);
  endtask

  initial begin
    int phase_counts [8];
    int sent;
    logic [ACTION_W-1:0] act;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed opening at the reset slot count
    send_request(ACT_SWAP_IN, 10'd0);
    send_request(ACT_FREE, 10'd1023);
    send_request(ACT_UNKNOWN, 10'h3FF);
    send_request(ACT_SWAP_OUT, 10'h3FF);
    send_request(ACT_SWAP_OUT, 10'd0);
    send_request(ACT_SWAP_OUT, 10'h155);
    send_request(ACT_SWAP_IN, 10'd0);
    send_request(ACT_FREE, 10'd1);
    send_request(ACT_SWAP_OUT, 10'h2AA);
    send_request(ACT_FREE, 10'd1);

    // shrink: used slot above the count is out of range
    write_slot_count(11'd2);
    send_request(ACT_SWAP_OUT, 10'd0);
    send_request(ACT_SWAP_OUT, 10'd0);
    send_request(ACT_FREE, 10'd2);
    send_request(ACT_SWAP_IN, 10'd1023);
    send_request(ACT_SWAP_IN, 10'd1);

    write_slot_count(11'd1024);
    send_request(ACT_FREE, 10'd2);

    write_slot_count(11'd0);
    send_request(ACT_SWAP_OUT, 10'd0);
    send_request(ACT_FREE, 10'd0);

    write_slot_count(11'h7FF);
    send_request(ACT_SWAP_IN, 10'd0);
    send_request(ACT_SWAP_OUT, 10'd0);

    // fill the table at a partial-word count, then work at its top end
    write_slot_count(COUNT_W'(FILL_COUNT));
    while (sb.free_below() != 0) begin
      send_request(ACT_SWAP_OUT, INDEX_W'($urandom_range(SLOTS - 1)));
    end
    send_request(ACT_SWAP_OUT, 10'd0);
    send_request(ACT_SWAP_IN, INDEX_W'(FILL_COUNT - 1));
    send_request(ACT_FREE, INDEX_W'(FILL_COUNT / 2));
    send_request(ACT_SWAP_OUT, 10'd0);
    send_request(ACT_SWAP_IN, INDEX_W'(FILL_COUNT - 1));
    send_request(ACT_FREE, INDEX_W'(FILL_COUNT));

    phase_counts = '{1024, 37, 2047, 1, 0, 300, 1025, 0};
    phase_counts[7] = $urandom_range(1024, 1);
    foreach (phase_counts[p]) begin
      write_slot_count(COUNT_W'(phase_counts[p]));
      calm = (p == 2);
      sent = 0;
      while (sent < PHASE_REQS) begin
        random_request(act);
        if (act != ACT_UNKNOWN) sent++;
        if (sent == 25 && p == 1) wait_idle(0);
      end
    end
    calm = 1'b0;

    wait_idle(40);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
